[rtl/core/n_queens_backtrack_search_top_defines.svh]
// ----------------------------------------------------------------------------
// N-queens search assertion macros
// Shared concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef N_QUEENS_BACKTRACK_SEARCH_TOP_DEFINES_SVH
`define N_QUEENS_BACKTRACK_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NQ_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NQ_NEVER(lbl, cond, msg) \
    `NQ_CHECK(lbl, !(cond), msg)
`else
`define NQ_CHECK(lbl, prop, msg)
`define NQ_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/core/nq_pkg.sv]
// ----------------------------------------------------------------------------
// N-queens search package
// Sizes, shared types and helper functions of the row-cell search chain.
// ----------------------------------------------------------------------------
package nq_pkg;

    localparam int MAX_SIZE = 8;
    localparam int COL_W    = 3;
    localparam int SIZE_W   = 4;
    localparam int ROW_W    = 4;
    localparam int CNT_W    = 6;
    localparam int PLACE_W  = MAX_SIZE * COL_W;
    localparam int MAX_SOL  = 18;

    typedef logic [MAX_SIZE-1:0] mask_t;

    typedef struct packed {
        mask_t cols;
        mask_t ld;
        mask_t rd;
    } mask_set_t;

    typedef struct packed {
        logic load;
        logic place;
    } cell_ctl_t;

    typedef struct packed {
        logic             seed_start;
        logic             place;
        logic [ROW_W-1:0] row;
    } ctrl_out_t;

    typedef struct packed {
        logic             sol;
        logic             fin;
        logic             bad;
        logic [CNT_W-1:0] count;
    } event_t;

    function automatic logic [COL_W-1:0] col_index(input mask_t q);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            if (q[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic mask_t size_mask(input logic [SIZE_W-1:0] n);
        mask_t m;
        for (int i = 0; i < MAX_SIZE; i++) begin
            m[i] = (SIZE_W'(i) < n);
        end
        return m;
    endfunction

endpackage

[rtl/core/nq_cell.sv]
// ----------------------------------------------------------------------------
// N-queens row cell
// Holds one row's attack masks, remaining candidates and placed queen;
// hands the updated masks to the next row.
// ----------------------------------------------------------------------------
module nq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  nq_pkg::cell_ctl_t ctl,
    input  nq_pkg::mask_set_t in_masks,
    input  nq_pkg::mask_t     seed,
    output nq_pkg::mask_set_t out_masks,
    output logic              rem_any,
    output logic [nq_pkg::COL_W-1:0] col
);
    import nq_pkg::*;

    mask_t cols_reg, ld_reg, rd_reg;
    mask_t rem_reg, rem_next;
    mask_t q_reg, q_next;
    mask_t pick;

    // lowest remaining column
    assign pick = rem_reg & (~rem_reg + mask_t'(1));

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        priority if (ctl.load)
        begin
            rem_next = seed;
        end
        else if (ctl.place)
        begin
            rem_next = rem_reg & ~pick;
            q_next   = pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cols_reg <= in_masks.cols;
            ld_reg   <= in_masks.ld;
            rd_reg   <= in_masks.rd;
        end
    end

    assign out_masks.cols = cols_reg | pick;
    assign out_masks.ld   = (ld_reg | pick) << 1;
    assign out_masks.rd   = (rd_reg | pick) >> 1;
    assign rem_any        = |rem_reg;
    assign col            = col_index(q_reg);

endmodule

[rtl/core/nq_ctrl.sv]
// ----------------------------------------------------------------------------
// N-queens search controller
// Row pointer and solution counter; steps the cell chain one node per cycle.
// ----------------------------------------------------------------------------
`include "n_queens_backtrack_search_top_defines.svh"

module nq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nq_pkg::COL_W-1:0]  first_column,
    input  logic [nq_pkg::SIZE_W-1:0] n_eff,
    input  logic                      cand,
    output logic                      busy,
    output nq_pkg::ctrl_out_t         ctl,
    output nq_pkg::event_t            ev
);
    import nq_pkg::*;

    typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] found_reg, found_next;
    logic             col_bad;

    assign col_bad = ({1'b0, first_column} >= n_eff);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        found_next     = found_reg;
        ctl.seed_start = 1'b0;
        ctl.place      = 1'b0;
        ctl.row        = row_reg;
        ev             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (col_bad)
                    begin
                        ev.fin = 1'b1;
                        ev.bad = 1'b1;
                    end
                    else
                    begin
                        ctl.seed_start = 1'b1;
                        row_next       = '0;
                        found_next     = '0;
                        state_next     = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                priority if (row_reg == n_eff)
                begin
                    ev.sol     = (found_reg < CNT_W'(MAX_SOL));
                    found_next = found_reg + CNT_W'(1);
                    row_next   = row_reg - ROW_W'(1);
                end
                else if (cand)
                begin
                    ctl.place = 1'b1;
                    row_next  = row_reg + ROW_W'(1);
                end
                else if (row_reg == '0)
                begin
                    ev.fin     = 1'b1;
                    ev.count   = found_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_next = row_reg - ROW_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            found_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            found_reg <= found_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    `NQ_NEVER(a_row_in_board, busy && (row_reg > n_eff), "row pointer beyond board")
    `NQ_CHECK(a_fin_idle, ev.fin |=> !busy, "busy after closing item")
    `NQ_CHECK(a_start_search, (start && !busy && !col_bad) |=> (busy && row_reg == '0), "search did not start at row zero")
    `NQ_CHECK(a_sol_back, (busy && row_reg == n_eff) |=> (row_reg == $past(row_reg) - ROW_W'(1)), "no backtrack after solution")

endmodule

[rtl/core/n_queens_backtrack_search_top.sv]
// ----------------------------------------------------------------------------
// N-queens backtracking search
// Depth-first search of all placements with a fixed queen in row zero.
// ----------------------------------------------------------------------------
// A run starts at an edge with start high and busy low. Busy then stays high
// while the search places each queen, lifts it again or reports the board it
// completes, and finally gives the closing item. Results are registered, so
// each is on the ports in the cycle after the one that found it; the closing
// item shows in the first cycle with busy low. A column off the board gives
// only the closing item, in the cycle after the accepting edge, and busy
// stays low. The first 18 solutions and the closing item appear on the
// result ports for exactly one cycle with result_valid high; the receiver
// cannot stall the block.
module n_queens_backtrack_search_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [nq_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  logic [nq_pkg::COL_W-1:0]   first_column,
    output logic                       result_valid,
    output logic [nq_pkg::PLACE_W-1:0] placement,
    output logic [nq_pkg::CNT_W-1:0]   solution_count,
    output logic                       is_final,
    output logic                       bad_column
);
    import nq_pkg::*;

    logic [SIZE_W-1:0] board_size_reg;
    logic [SIZE_W-1:0] n_eff;
    mask_t             bmask;
    logic              cand;
    ctrl_out_t         ctl;
    event_t            ev;

    cell_ctl_t        cell_ctl [MAX_SIZE];
    mask_set_t        cell_in  [MAX_SIZE];
    mask_set_t        cell_out [MAX_SIZE];
    mask_t            cell_seed[MAX_SIZE];
    logic [MAX_SIZE-1:0] rem_any;
    logic [COL_W-1:0] cell_col [MAX_SIZE];
    logic [PLACE_W-1:0] board_bits;

    logic               valid_reg;
    logic [PLACE_W-1:0] placement_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               final_reg;
    logic               bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_size_reg <= SIZE_W'(MAX_SIZE);
        end
        else if (cfg_we)
        begin
            board_size_reg <= cfg_data;
        end
    end

    assign n_eff = (board_size_reg > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : board_size_reg;
    assign bmask = size_mask(n_eff);
    assign cand  = rem_any[ctl.row[COL_W-1:0]];

    nq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .first_column (first_column),
        .n_eff        (n_eff),
        .cand         (cand),
        .busy         (busy),
        .ctl          (ctl),
        .ev           (ev)
    );

    for (genvar r = 0; r < MAX_SIZE; r++)
    begin : g_row
        if (r == 0)
        begin : g_first
            assign cell_in[r]      = '0;
            assign cell_seed[r]    = mask_t'(1) << first_column;
            assign cell_ctl[r].load = ctl.seed_start;
        end
        else
        begin : g_rest
            assign cell_in[r]   = cell_out[r-1];
            assign cell_seed[r] = ~(cell_out[r-1].cols | cell_out[r-1].ld
                                    | cell_out[r-1].rd) & bmask;
            assign cell_ctl[r].load = ctl.place && (ctl.row == ROW_W'(r - 1));
        end
        assign cell_ctl[r].place = ctl.place && (ctl.row == ROW_W'(r));

        nq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[r]),
            .in_masks  (cell_in[r]),
            .seed      (cell_seed[r]),
            .out_masks (cell_out[r]),
            .rem_any   (rem_any[r]),
            .col       (cell_col[r])
        );

        assign board_bits[r*COL_W +: COL_W] = bmask[r] ? cell_col[r] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ev.sol | ev.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        placement_reg <= ev.sol ? board_bits : '0;
        count_reg     <= ev.count;
        final_reg     <= ev.fin;
        bad_reg       <= ev.bad;
    end

    assign result_valid   = valid_reg;
    assign placement      = placement_reg;
    assign solution_count = count_reg;
    assign is_final       = final_reg;
    assign bad_column     = bad_reg;

endmodule
